/* rtl/core/duri_pkg.sv */
// Shared types, codes and helper functions for the data URI payload decoder.
// No dependencies; every other file in rtl/core refers to this package by scope.
package duri_pkg;

   // Result queue sizing
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Parse phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_TAIL    = 2'd2;
   localparam logic [1:0] PH_ERROR   = 2'd3;

   // Percent escape progress
   localparam logic [1:0] PS_IDLE = 2'd0;
   localparam logic [1:0] PS_PCT  = 2'd1;
   localparam logic [1:0] PS_HELD = 2'd2;

   // Length of the "base64" marker after a semicolon
   localparam logic [2:0] MARKER_LEN = 3'd6;

   // Status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_COMMA = 1'b1;

   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic       status;
   } rsp_entry_type;

   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
   } rsp_pair_type;

   typedef struct packed {
      logic        stopped;
      logic [11:0] acc;
      logic [1:0]  bits_pending;
   } b64_state_type;

   typedef struct packed {
      b64_state_type st;
      logic [7:0]    data;
      logic          data_ok;
   } sink_result_type;

   function automatic logic [7:0] marker_char(logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h62; // b
         3'd1:    ch = 8'h61; // a
         3'd2:    ch = 8'h73; // s
         3'd3:    ch = 8'h65; // e
         3'd4:    ch = 8'h36; // 6
         3'd5:    ch = 8'h34; // 4
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Top bit flags a character inside the base64 alphabet
   function automatic logic [6:0] sextet_of(logic [7:0] c);
      logic [6:0] s;
      if (c inside {[8'h41:8'h5A]}) begin
         s = {1'b1, 6'(c - 8'h41)};
      end else if (c inside {[8'h61:8'h7A]}) begin
         s = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c inside {[8'h30:8'h39]}) begin
         s = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         s = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         s = {1'b1, 6'd63};
      end else begin
         s = 7'd0;
      end
      return s;
   endfunction

   // Hex digit value; anything else folds to lower case and wraps mod 256
   function automatic logic [7:0] digit_value(logic [7:0] c);
      logic [7:0] lc;
      logic [7:0] dv;
      lc = c;
      if (c inside {[8'h30:8'h39]}) begin
         dv = c - 8'h30;
      end else begin
         if (c inside {[8'h41:8'h5A]}) begin
            lc = c + 8'd32;
         end
         dv = lc - 8'd87;
      end
      return dv;
   endfunction

   function automatic sink_result_type b64_sink(b64_state_type st, logic mode,
                                                logic [7:0] v);
      sink_result_type r;
      logic [6:0]      s;
      r.st      = st;
      r.data    = v;
      r.data_ok = 1'b0;
      s         = sextet_of(v);
      if (!mode) begin
         r.data_ok = 1'b1;
      end else if (!st.stopped) begin
         if (!s[6]) begin
            r.st.stopped = 1'b1;
         end else begin
            r.st.acc = {st.acc[5:0], s[5:0]};
            case (st.bits_pending)
               2'd1: begin
                  r.data    = r.st.acc[7:0];
                  r.data_ok = 1'b1;
               end
               2'd2: begin
                  r.data    = r.st.acc[9:2];
                  r.data_ok = 1'b1;
               end
               2'd3: begin
                  r.data    = r.st.acc[11:4];
                  r.data_ok = 1'b1;
               end
               default: r.data_ok = 1'b0;
            endcase
            r.st.bits_pending = (st.bits_pending == 2'd0) ? 2'd3 : st.bits_pending - 2'd1;
         end
      end
      return r;
   endfunction

endpackage

/* rtl/core/duri_core.sv */
// Per-character decode: header scan, percent decoding, base64 packing.
// Holds the parse state; uses duri_pkg for codes, types and helpers.
module duri_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            char_in,
   input  logic                  is_last,
   output duri_pkg::rsp_pair_type pair
);

   logic [1:0]              phase_ff, phase_in;
   logic [2:0]              match_count_ff, match_count_in;
   logic                    match_armed_ff, match_armed_in;
   logic                    base64_mode_ff, base64_mode_in;
   logic [1:0]              pct_state_ff, pct_state_in;
   logic [7:0]              held_char_ff, held_char_in;
   duri_pkg::b64_state_type b64_ff, b64_in;

   logic                      ends;
   logic [7:0]                held_dv;
   logic                      s0_ok, s1_ok;
   logic [7:0]                s0_val, s1_val;
   duri_pkg::sink_result_type r0, r1;
   duri_pkg::rsp_entry_type   e0, e1;
   logic [1:0]                n;
   logic [1:0]                phase_next;
   logic                      err;

   assign ends    = (char_in == duri_pkg::CH_QUERY) || (char_in == duri_pkg::CH_HASH);
   assign held_dv = duri_pkg::digit_value(held_char_ff);

   always_comb begin
      phase_next     = phase_ff;
      match_count_in = match_count_ff;
      match_armed_in = match_armed_ff;
      base64_mode_in = base64_mode_ff;
      pct_state_in   = pct_state_ff;
      held_char_in   = held_char_ff;
      s0_ok          = 1'b0;
      s1_ok          = 1'b0;
      s0_val         = char_in;
      s1_val         = char_in;

      case (phase_ff)
         duri_pkg::PH_HEADER: begin
            if (char_in == duri_pkg::CH_COMMA) begin
               base64_mode_in = match_armed_ff &&
                                (match_count_ff == duri_pkg::MARKER_LEN);
               phase_next     = duri_pkg::PH_PAYLOAD;
            end else if (ends) begin
               phase_next = duri_pkg::PH_ERROR;
            end else if (char_in == duri_pkg::CH_SEMI) begin
               match_armed_in = 1'b1;
               match_count_in = 3'd0;
            end else if (match_armed_ff && (match_count_ff < duri_pkg::MARKER_LEN) &&
                         (char_in == duri_pkg::marker_char(match_count_ff))) begin
               match_count_in = match_count_ff + 3'd1;
            end else begin
               match_armed_in = 1'b0;
               match_count_in = 3'd0;
            end
            if (is_last && (phase_next == duri_pkg::PH_HEADER)) begin
               phase_next = duri_pkg::PH_ERROR;
            end
         end
         duri_pkg::PH_PAYLOAD: begin
            if (ends) begin
               // flush a pending escape as plain text
               s0_ok        = (pct_state_ff != duri_pkg::PS_IDLE);
               s0_val       = duri_pkg::CH_PERCENT;
               s1_ok        = (pct_state_ff == duri_pkg::PS_HELD);
               s1_val       = held_char_ff;
               pct_state_in = duri_pkg::PS_IDLE;
               phase_next   = duri_pkg::PH_TAIL;
            end else begin
               case (pct_state_ff)
                  duri_pkg::PS_IDLE: begin
                     if (char_in == duri_pkg::CH_PERCENT) begin
                        pct_state_in = duri_pkg::PS_PCT;
                        s0_ok        = is_last;
                        s0_val       = duri_pkg::CH_PERCENT;
                     end else begin
                        s0_ok = 1'b1;
                     end
                  end
                  duri_pkg::PS_PCT: begin
                     held_char_in = char_in;
                     pct_state_in = duri_pkg::PS_HELD;
                     s0_ok        = is_last;
                     s0_val       = duri_pkg::CH_PERCENT;
                     s1_ok        = is_last;
                     s1_val       = char_in;
                  end
                  default: begin
                     s0_ok  = 1'b1;
                     s0_val = {held_dv[3:0], 4'h0} | duri_pkg::digit_value(char_in);
                     pct_state_in = duri_pkg::PS_IDLE;
                  end
               endcase
            end
         end
         default: begin
            phase_next = phase_ff;
         end
      endcase

      r0 = s0_ok ? duri_pkg::b64_sink(b64_ff, base64_mode_ff, s0_val)
                 : duri_pkg::sink_result_type'{st: b64_ff, data: 8'h00, data_ok: 1'b0};
      r1 = s1_ok ? duri_pkg::b64_sink(r0.st, base64_mode_ff, s1_val)
                 : duri_pkg::sink_result_type'{st: r0.st, data: 8'h00, data_ok: 1'b0};
      b64_in = r1.st;
      phase_in = phase_next;

      err = (phase_next == duri_pkg::PH_ERROR) ? duri_pkg::STATUS_NO_COMMA
                                               : duri_pkg::STATUS_OK;
      e0  = '{out_byte: r0.data, byte_valid: 1'b1, done_res: 1'b0,
              status: duri_pkg::STATUS_OK};
      e1  = '{out_byte: r1.data, byte_valid: 1'b1, done_res: 1'b0,
              status: duri_pkg::STATUS_OK};
      n   = {1'b0, r0.data_ok} + {1'b0, r1.data_ok};

      pair.first  = r0.data_ok ? e0 : e1;
      pair.second = e1;
      if (is_last) begin
         if (n == 2'd0) begin
            n          = 2'd1;
            pair.first = '{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1,
                           status: err};
         end else if (n == 2'd1) begin
            pair.first.done_res = 1'b1;
            pair.first.status   = err;
         end else begin
            pair.second.done_res = 1'b1;
            pair.second.status   = err;
         end
      end
      pair.count = fire ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && is_last)) begin
         phase_ff       <= duri_pkg::PH_HEADER;
         match_count_ff <= 3'd0;
         match_armed_ff <= 1'b0;
         base64_mode_ff <= 1'b0;
         pct_state_ff   <= duri_pkg::PS_IDLE;
         held_char_ff   <= 8'h00;
         b64_ff         <= '0;
      end else if (fire) begin
         phase_ff       <= phase_in;
         match_count_ff <= match_count_in;
         match_armed_ff <= match_armed_in;
         base64_mode_ff <= base64_mode_in;
         pct_state_ff   <= pct_state_in;
         held_char_ff   <= held_char_in;
         b64_ff         <= b64_in;
      end
   end

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire && is_last |-> pair.count != 2'd0)
      else $error("last character produced no result");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && is_last |=> phase_ff == duri_pkg::PH_HEADER &&
                          pct_state_ff == duri_pkg::PS_IDLE && !b64_ff.stopped)
      else $error("state not cleared after last character");

   a_done_only_on_last: assert property (@(posedge clock) disable iff (reset)
      fire && !is_last |-> !pair.first.done_res && !pair.second.done_res &&
                           !pair.first.status && !pair.second.status)
      else $error("done or error flagged before the last character");

endmodule

/* rtl/core/duri_rsp_fifo.sv */
// Result queue: takes up to two result beats per cycle, hands out one.
// Uses duri_pkg for the entry type and queue sizing.
module duri_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  duri_pkg::rsp_pair_type pair,
   input  logic                   pop,
   output logic                   has_room,
   output logic                   out_valid,
   output duri_pkg::rsp_entry_type out_entry
);

   duri_pkg::rsp_entry_type              entries_ff [duri_pkg::RSP_DEPTH];
   logic [duri_pkg::RSP_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [duri_pkg::RSP_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [duri_pkg::RSP_CNT_W-1:0]       count_ff, count_in;
   logic [duri_pkg::RSP_PTR_W-1:0]       wr_next;

   assign wr_next   = wr_ptr_ff + duri_pkg::RSP_PTR_W'(1);
   assign has_room  = count_ff <= duri_pkg::RSP_CNT_W'(duri_pkg::RSP_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + duri_pkg::RSP_PTR_W'(pair.count);
      rd_ptr_in = pop ? rd_ptr_ff + duri_pkg::RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + duri_pkg::RSP_CNT_W'(pair.count) -
                  duri_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= pair.first;
      end
      if (pair.count == 2'd2) begin
         entries_ff[wr_next] <= pair.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pair.count != 2'd0 |-> has_room)
      else $error("result beats pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= duri_pkg::RSP_CNT_W'(duri_pkg::RSP_DEPTH))
      else $error("result queue count out of range");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && pair.count == 2'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not reduce the queue count");

endmodule

/* rtl/core/data_uri_payload_decoder.sv */
// Data URI payload decoder, top level.
// Input channel req_*: one URI character per beat after the scheme colon,
// req_is_last on the final character. Result channel rsp_*: decoded bytes,
// zero to two beats per character; the last character always yields a beat
// with rsp_done_res set, carrying rsp_status (1 = no comma in the header).
// Header mode scans for the comma and a ";base64" marker; payload is
// percent-decoded and then passed straight out or packed through base64.
// An accepted character waits in the input register; its results then pass
// through the result queue to the rsp ports.
// Throughput: one character per cycle while each gives at most one byte and
// the receiver does not stall; a character giving two bytes needs two beats
// on the rsp side, and the 4-entry result queue absorbs them. The input
// register advances only when the queue has room for two beats.
// Reset (synchronous, active high) empties the queue and returns the parser
// to header mode; the parser also returns there after every last character.
// While rsp_stall is high the head beat holds; with a character waiting and
// more than two beats queued, req_stall rises until the receiver drains them.
module data_uri_payload_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_done_res,
   output logic       rsp_status
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_char_ff;
   logic                    in_last_ff;
   logic                    fire;
   logic                    has_room;
   logic                    accept;
   duri_pkg::rsp_pair_type  pair;
   duri_pkg::rsp_entry_type head;

   assign fire      = in_valid_ff && has_room;
   assign req_stall = in_valid_ff && !has_room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the character until the core takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
      end
   end

   duri_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .char_in (in_char_ff),
      .is_last (in_last_ff),
      .pair    (pair)
   );

   duri_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .pop       (rsp_valid && !rsp_stall),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_entry (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_byte_valid = head.byte_valid;
   assign rsp_done_res   = head.done_res;
   assign rsp_status     = head.status;

endmodule

/* tb/data_uri_payload_decoder_tb.sv */
// Self-checking testbench for data_uri_payload_decoder: random and directed URIs,
// a bit-accurate decode predictor in a scoreboard class, random stalls on both sides.
// Depends on duri_pkg for the result beat type, character codes and parse phases.
module data_uri_payload_decoder_tb;

   localparam int CHAR_TARGET = 1420;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_AFTER  = 300;
   localparam int HOLD_CYCLES = 80;

   // Predicts the result beats of each character and checks the beats that come out.
   class uri_decode_scoreboard;
      duri_pkg::rsp_entry_type expected_beats[$];
      logic [7:0]    new_bytes[$];
      string         marker_word = "base64";
      string         b64_symbols =
         "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      int            mismatches;
      int            beats_checked;
      int            chars_noted;
      int            uris_done;
      int            b64_uris;
      int            no_comma_uris;
      logic [1:0]    phase;
      logic [2:0]    marker_pos;
      logic          marker_armed;
      logic          b64_on;
      logic [1:0]    escape;
      logic [7:0]    held;
      logic [11:0]   bit_buf;
      logic [1:0]    b64_left;
      logic          b64_dead;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         phase        = duri_pkg::PH_HEADER;
         marker_pos   = '0;
         marker_armed = 1'b0;
         b64_on       = 1'b0;
         escape       = duri_pkg::PS_IDLE;
         held         = '0;
         bit_buf      = '0;
         b64_left     = '0;
         b64_dead     = 1'b0;
      endfunction

      function int alphabet_index(logic [7:0] c);
         int i;
         for (i = 0; i < 64; i++) begin
            if (c == 8'(b64_symbols[i])) return i;
         end
         return -1;
      endfunction

      // Hex digit, or anything else folded to lower case and taken from 'a' - 10
      function logic [7:0] escape_digit(logic [7:0] c);
         logic [7:0] lc;
         if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
         lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
         return lc - 8'd87;
      endfunction

      function void emit(logic [7:0] v);
         if (new_bytes.size() < 2) new_bytes.insert(new_bytes.size(), v);
      endfunction

      function void feed(logic [7:0] v);
         int idx;
         int shift;
         if (!b64_on) begin
            emit(v);
            return;
         end
         if (b64_dead) return;
         idx = alphabet_index(v);
         if (idx < 0) begin
            b64_dead = 1'b1;
            return;
         end
         bit_buf = {bit_buf[5:0], 6'(idx)};
         if (b64_left != 2'd0) begin
            shift = 2 * int'(b64_left) - 2;
            emit(8'(bit_buf >> shift));
            b64_left = b64_left - 2'd1;
         end else begin
            b64_left = 2'd3;
         end
      endfunction

      // Pass an unfinished escape through as plain characters
      function void flush_escape();
         if (escape == duri_pkg::PS_PCT) begin
            feed(duri_pkg::CH_PERCENT);
         end else if (escape == duri_pkg::PS_HELD) begin
            feed(duri_pkg::CH_PERCENT);
            feed(held);
         end
         escape = duri_pkg::PS_IDLE;
      endfunction

      function void payload_char(logic [7:0] c);
         logic [7:0] hi;
         logic [7:0] lo;
         if (escape == duri_pkg::PS_IDLE) begin
            if (c == duri_pkg::CH_PERCENT) escape = duri_pkg::PS_PCT;
            else feed(c);
         end else if (escape == duri_pkg::PS_PCT) begin
            held   = c;
            escape = duri_pkg::PS_HELD;
         end else begin
            hi = escape_digit(held);
            lo = escape_digit(c);
            feed({hi[3:0], 4'h0} | lo);
            escape = duri_pkg::PS_IDLE;
         end
      endfunction

      function void note_char(logic [7:0] c, logic last);
         logic                    ends;
         logic [7:0]              want_char;
         duri_pkg::rsp_entry_type beat;
         int                      k;
         new_bytes.delete();
         chars_noted++;
         ends = (c == duri_pkg::CH_QUERY) || (c == duri_pkg::CH_HASH);
         if (phase == duri_pkg::PH_HEADER) begin
            want_char = (marker_pos < duri_pkg::MARKER_LEN) ? 8'(marker_word[marker_pos])
                                                            : 8'h00;
            if (c == duri_pkg::CH_COMMA) begin
               b64_on = marker_armed && (marker_pos == duri_pkg::MARKER_LEN);
               phase  = duri_pkg::PH_PAYLOAD;
            end else if (ends) begin
               phase = duri_pkg::PH_ERROR;
            end else if (c == duri_pkg::CH_SEMI) begin
               marker_armed = 1'b1;
               marker_pos   = '0;
            end else if (marker_armed && marker_pos < duri_pkg::MARKER_LEN &&
                         c == want_char) begin
               marker_pos = marker_pos + 3'd1;
            end else begin
               marker_armed = 1'b0;
               marker_pos   = '0;
            end
            if (last && phase == duri_pkg::PH_HEADER) phase = duri_pkg::PH_ERROR;
         end else if (phase == duri_pkg::PH_PAYLOAD) begin
            if (ends) begin
               flush_escape();
               phase = duri_pkg::PH_TAIL;
            end else begin
               payload_char(c);
               if (last) flush_escape();
            end
         end

         for (k = 0; k < new_bytes.size(); k++) begin
            beat.out_byte   = new_bytes[k];
            beat.byte_valid = 1'b1;
            beat.done_res   = last && (k == new_bytes.size() - 1);
            beat.status     = (beat.done_res && phase == duri_pkg::PH_ERROR)
                              ? duri_pkg::STATUS_NO_COMMA : duri_pkg::STATUS_OK;
            expected_beats.insert(expected_beats.size(), beat);
         end
         if (last) begin
            // no byte on the last character: a bare end-of-URI beat
            if (new_bytes.size() == 0) begin
               beat.out_byte   = 8'h00;
               beat.byte_valid = 1'b0;
               beat.done_res   = 1'b1;
               beat.status     = (phase == duri_pkg::PH_ERROR) ? duri_pkg::STATUS_NO_COMMA
                                                               : duri_pkg::STATUS_OK;
               expected_beats.insert(expected_beats.size(), beat);
            end
            uris_done++;
            if (b64_on) b64_uris++;
            if (phase == duri_pkg::PH_ERROR) no_comma_uris++;
            clear_state();
         end
      endfunction

      function void check_beat(logic [7:0] got_byte, logic got_valid, logic got_done,
                               logic got_status);
         duri_pkg::rsp_entry_type want;
         beats_checked++;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: out_byte %02h", got_byte);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         if (got_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got_byte);
            mismatches++;
         end
         if (got_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got_valid);
            mismatches++;
         end
         if (got_done !== want.done_res) begin
            $error("done_res: expected %0b, got %0b", want.done_res, got_done);
            mismatches++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, got_status);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_in;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_done_res;
   logic       rsp_status;

   uri_decode_scoreboard board = new();
   logic [7:0] uri_text[$];
   bit         holding;
   bit         hold_done;
   int         quiet_cycles;
   int         held_off_cycles;

   data_uri_payload_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status)
   );

   always #5 clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic void add_char(logic [7:0] c);
      uri_text.insert(uri_text.size(), c);
   endfunction

   function automatic void add_text(string s);
      foreach (s[i]) uri_text.insert(uri_text.size(), 8'(s[i]));
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] b64_symbol();
      return 8'(board.b64_symbols[$urandom_range(0, 63)]);
   endfunction

   function automatic void add_escape(logic [7:0] v);
      bit upper;
      upper = $urandom_range(0, 1);
      add_char(duri_pkg::CH_PERCENT);
      add_char(hex_char(v[7:4], upper));
      add_char(hex_char(v[3:0], upper));
   endfunction

   function automatic void add_payload_char(bit b64_style);
      int r;
      r = $urandom_range(0, 99);
      if (b64_style) begin
         if (r < 80) add_char(b64_symbol());
         else if (r < 88) add_escape(b64_symbol());
         else if (r < 93) add_char(8'h3D); // padding stops the stream
         else add_char(8'($urandom));
      end else begin
         if (r < 45) begin
            add_char(8'($urandom_range(8'h20, 8'h7E)));
         end else if (r < 65) begin
            add_char(8'($urandom));
         end else if (r < 85) begin
            add_escape(8'($urandom));
         end else begin
            add_char(duri_pkg::CH_PERCENT);
            add_char(8'($urandom));
            add_char(8'($urandom));
         end
      end
   endfunction

   function automatic void build_random_uri();
      int r;
      int n;
      bit b64_style;
      b64_style = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         n = $urandom_range(1, 12);
         repeat (n) add_char(8'($urandom));
         return;
      end
      n = $urandom_range(0, 6);
      repeat (n) begin
         add_char(($urandom_range(0, 7) == 0) ? 8'h2F : 8'($urandom_range(8'h61, 8'h7A)));
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
         add_text(";base64");
         b64_style = 1'b1;
      end else if (r < 55) begin
         add_text(";charset=x;base64");
         b64_style = 1'b1;
      end else if (r < 62) begin
         add_text(";base6");
      end else if (r < 68) begin
         add_text(";bAse64");
      end else if (r < 74) begin
         add_text(";base64;x");
      end
      r = $urandom_range(0, 99);
      if (r >= 92) begin
         // header with no comma: ends on the last character or on a query or hash
         if (r >= 96) begin
            add_char(r[0] ? duri_pkg::CH_QUERY : duri_pkg::CH_HASH);
            repeat ($urandom_range(0, 3)) add_char(8'($urandom));
         end
         if (uri_text.size() == 0) add_char(8'h61);
         return;
      end
      add_char(duri_pkg::CH_COMMA);
      n = $urandom_range(0, 16);
      repeat (n) add_payload_char(b64_style);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         add_char(duri_pkg::CH_PERCENT);
         if (r < 4) add_char(hex_char(4'($urandom), r[0]));
      end else if (r < 16) begin
         add_char(r[0] ? duri_pkg::CH_QUERY : duri_pkg::CH_HASH);
         repeat ($urandom_range(0, 4)) add_char(8'($urandom));
      end
   endfunction

   // Offer one character; hold it until the block takes the beat
   task automatic send_char(input logic [7:0] c, input logic last, input bit calm);
      int gap;
      gap = (calm || holding) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      board.note_char(c, last);
      @(negedge clock);
   endtask

   task automatic send_uri();
      bit calm;
      calm = ($urandom_range(0, 4) == 0);
      foreach (uri_text[i]) send_char(uri_text[i], i == uri_text.size() - 1, calm);
      uri_text.delete();
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_char_in <= '0;
      req_is_last <= 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      add_text("?x");
      send_uri();
      add_text("a");
      send_uri();
      add_text(",%z");
      add_char(8'hFF);
      send_uri();
      add_text(",%4");
      send_uri();
      add_text(",%");
      send_uri();
      add_text(";base64,/w=");
      send_uri();
      add_text(",#");
      add_char(8'h00);
      send_uri();

      while (board.chars_noted < CHAR_TARGET) begin
         build_random_uri();
         send_uri();
      end
      req_valid <= 1'b0;

      while (board.expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d URIs over %0d characters: %0d decoded as base64, %0d without a comma.",
               board.uris_done, board.chars_noted, board.b64_uris, board.no_comma_uris);
      $display("Checked %0d result beats; input was held off for %0d cycles.",
               board.beats_checked, held_off_cycles);
      if (board.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Receiver: random stalls, calm stretches, and one long hold-off to fill the block
   initial begin
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left  = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && board.beats_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            holding   = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            holding   = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 60);
            else stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_beat(rsp_out_byte, rsp_byte_valid, rsp_done_res, rsp_status);
      end
   end

   // Watchdog: count cycles in which no beat moves on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (!reset && req_valid && req_stall) held_off_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

endmodule
